// ===== hdl/pbc_pkg.sv =====
package pbc_pkg;

  localparam int MAX_PARTICLES = 16;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int NUM_W = 51;
  localparam int DEN_W = 17;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_LEFT    = 3'd1;
  localparam logic [2:0] EV_RIGHT   = 3'd2;
  localparam logic [2:0] EV_TOP     = 3'd3;
  localparam logic [2:0] EV_BOTTOM  = 3'd4;
  localparam logic [2:0] EV_COLLIDE = 3'd5;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [14:0] ARENA_RESET = 15'd500;

  typedef struct packed {
    logic [15:0]        particle_mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               frame_last;
  } particle_t;

  typedef struct packed {
    logic [5:0]         particle_index;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [2:0]         event_kind;
    logic               run_last;
  } result_t;

  typedef struct packed {
    logic [15:0]        mass;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } entry_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [2:0]         ev;
    logic               last;
    logic [15:0]        mi;
    logic [15:0]        mj;
    logic signed [31:0] vjx;
    logic signed [31:0] vjy;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_RDI, F_WALL, F_RDJ, F_DIFF, F_SQ, F_CMP, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SUM, B_DIV, B_FIN
  } back_state_t;

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end
    return -v;
  endfunction

endpackage

// ===== hdl/pbc_queue.sv =====
module pbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pbc_pkg::job_t  wr_data,
  input  logic           pop,
  output logic           empty,
  output pbc_pkg::job_t  rd_data
);
  import pbc_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pbc_front.sv =====
module pbc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pbc_pkg::particle_t  particle,
  input  logic [14:0]         arena_width,
  input  logic [14:0]         arena_height,
  output logic                job_push,
  input  logic                job_full,
  output pbc_pkg::job_t       job
);
  import pbc_pkg::*;

  front_state_t       state;
  front_state_t       state_next;
  entry_t             mem [MAX_PARTICLES];
  entry_t             rd_data;
  entry_t             ent_i;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   i;
  logic [IDX_W-1:0]   j;
  logic               accept;
  logic               room;
  logic               last_i;
  logic               last_j;
  logic               skip;
  logic               near;
  logic signed [32:0] dx_full;
  logic signed [32:0] dy_full;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [35:0] prod_x;
  logic signed [35:0] prod_y;
  logic [32:0]        sqx;
  logic [32:0]        sqy;
  logic signed [31:0] xmax;
  logic signed [31:0] ymax;
  job_t               wall_job;
  job_t               job_r;

  assign accept     = push && !full;
  assign room       = (count < CNT_W'(MAX_PARTICLES));
  assign count_next = room ? count + 1'b1 : count;
  assign last_i     = ({1'b0, i} == n - 1'b1);
  assign last_j     = ({1'b0, j} == n - 1'b1);
  assign rd_addr    = (state == F_RDI) ? i : j;
  assign xmax       = $signed({1'b0, arena_width, 16'h0000});
  assign ymax       = $signed({1'b0, arena_height, 16'h0000});

  assign dx_full = $signed({ent_i.px[31], ent_i.px}) - $signed({rd_data.px[31], rd_data.px});
  assign dy_full = $signed({ent_i.py[31], ent_i.py}) - $signed({rd_data.py[31], rd_data.py});
  assign skip    = (i == j) || (dx_full > 33'sd65536) || (dx_full < -33'sd65536)
                   || (dy_full > 33'sd65536) || (dy_full < -33'sd65536);
  assign prod_x  = dx * dx;
  assign prod_y  = dy * dy;
  assign near    = ({1'b0, sqx} + {1'b0, sqy}) <= 34'h1_0000_0000;

  always_comb begin
    wall_job       = '0;
    wall_job.index = 6'(i);
    wall_job.px    = rd_data.px;
    wall_job.py    = rd_data.py;
    wall_job.vx    = rd_data.vx;
    wall_job.vy    = rd_data.vy;
    wall_job.ev    = EV_NONE;
    wall_job.last  = last_i;
    wall_job.mi    = rd_data.mass;
    wall_job.mj    = rd_data.mass;
    wall_job.vjx   = rd_data.vx;
    wall_job.vjy   = rd_data.vy;
    priority if (rd_data.px < 0) begin
      wall_job.px = '0;
      wall_job.vx = neg_sat(rd_data.vx);
      wall_job.ev = EV_LEFT;
    end else if (rd_data.px > xmax) begin
      wall_job.px = xmax;
      wall_job.vx = neg_sat(rd_data.vx);
      wall_job.ev = EV_RIGHT;
    end else if (rd_data.py < 0) begin
      wall_job.py = '0;
      wall_job.vy = neg_sat(rd_data.vy);
      wall_job.ev = EV_TOP;
    end else if (rd_data.py > ymax) begin
      wall_job.py = ymax;
      wall_job.vy = neg_sat(rd_data.vy);
      wall_job.ev = EV_BOTTOM;
    end else begin
      wall_job.ev = EV_NONE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept && particle.frame_last && count_next != '0) begin
          state_next = F_RDI;
        end
      end
      F_RDI: begin
        state_next = F_WALL;
      end
      F_WALL: begin
        state_next = (wall_job.ev != EV_NONE) ? F_PUSH : F_RDJ;
      end
      F_RDJ: begin
        state_next = F_DIFF;
      end
      F_DIFF: begin
        if (skip) begin
          state_next = last_j ? F_PUSH : F_RDJ;
        end else begin
          state_next = F_SQ;
        end
      end
      F_SQ: begin
        state_next = F_CMP;
      end
      F_CMP: begin
        state_next = (near || last_j) ? F_PUSH : F_RDJ;
      end
      F_PUSH: begin
        if (!job_full) begin
          state_next = last_i ? F_IDLE : F_RDI;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_comb begin
    full     = (state != F_IDLE);
    job_push = (state == F_PUSH);
    job      = job_r;
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count[IDX_W-1:0]] <= '{mass: particle.particle_mass, px: particle.pos_x,
                                 py: particle.pos_y, vx: particle.vel_x,
                                 vy: particle.vel_y};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_WALL: begin
        ent_i <= rd_data;
        job_r <= wall_job;
        j     <= '0;
      end
      F_DIFF: begin
        dx <= dx_full[17:0];
        dy <= dy_full[17:0];
        if (skip && !last_j) begin
          j <= j + 1'b1;
        end
      end
      F_SQ: begin
        sqx <= prod_x[32:0];
        sqy <= prod_y[32:0];
      end
      F_CMP: begin
        if (near) begin
          job_r.ev  <= EV_COLLIDE;
          job_r.mj  <= rd_data.mass;
          job_r.vjx <= rd_data.vx;
          job_r.vjy <= rd_data.vy;
        end else if (!last_j) begin
          j <= j + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
      n     <= '0;
      i     <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (particle.frame_last) begin
          n     <= count_next;
          count <= '0;
          i     <= '0;
        end else begin
          count <= count_next;
        end
      end
      if (state == F_PUSH && !job_full) begin
        i <= i + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pbc_back.sv =====
module pbc_back (
  input  logic               clk,
  input  logic               rst,
  input  pbc_pkg::job_t      job,
  input  logic               job_empty,
  output logic               job_pop,
  output pbc_pkg::result_t   result,
  output logic               empty,
  input  logic               pop
);
  import pbc_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  job_t                 cur;
  job_t                 fin_job;
  logic                 axis;
  logic signed [48:0]   p1;
  logic signed [48:0]   p2;
  logic signed [NUM_W-1:0] num;
  logic                 num_neg;
  logic [NUM_W-1:0]     quo;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       rem_sh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 div_done;
  logic signed [31:0]   vi;
  logic signed [31:0]   vj;
  logic signed [16:0]   mdiff;
  logic signed [31:0]   vsat;
  logic                 out_valid;
  logic                 take;
  result_t              res;

  function automatic result_t to_result(input job_t jb);
    result_t r;
    r.particle_index = jb.index;
    r.new_pos_x      = jb.px;
    r.new_pos_y      = jb.py;
    r.new_vel_x      = jb.vx;
    r.new_vel_y      = jb.vy;
    r.event_kind     = jb.ev;
    r.run_last       = jb.last;
    return r;
  endfunction

  assign vi       = axis ? cur.vy : cur.vx;
  assign vj       = axis ? cur.vjy : cur.vjx;
  assign mdiff    = $signed({1'b0, cur.mi}) - $signed({1'b0, cur.mj});
  assign num      = NUM_W'(p1) + (NUM_W'(p2) <<< 1);
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign div_done = (cnt == DIV_CNT_W'(NUM_W - 1));

  always_comb begin
    priority if (den == '0) begin
      vsat = '0;
    end else if (num_neg) begin
      vsat = (quo > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end else begin
      vsat = (quo > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end
  end

  always_comb begin
    fin_job    = cur;
    fin_job.vy = vsat;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (take && job.ev == EV_COLLIDE) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        state_next = B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        state_next = axis ? B_IDLE : B_MUL;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    take    = (state == B_IDLE) && !job_empty && !out_valid;
    job_pop = take;
    empty   = !out_valid;
    result  = res;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (take) begin
          cur  <= job;
          axis <= 1'b0;
          res  <= to_result(job);
        end
      end
      B_MUL: begin
        p1 <= vi * mdiff;
        p2 <= vj * $signed({1'b0, cur.mj});
      end
      B_SUM: begin
        num_neg <= num[NUM_W-1];
        quo     <= num[NUM_W-1] ? NUM_W'(-num) : num;
        rem     <= '0;
        den     <= DEN_W'(cur.mi) + DEN_W'(cur.mj);
        cnt     <= '0;
      end
      B_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= DEN_W'(rem_sh - {1'b0, den});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      B_FIN: begin
        axis <= 1'b1;
        if (axis) begin
          res <= to_result(fin_job);
        end else begin
          cur.vx <= vsat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (take && job.ev != EV_COLLIDE) begin
        out_valid <= 1'b1;
      end else if (state == B_FIN && axis) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

endmodule

// ===== hdl/particle_bounce_elastic_collide.sv =====
// channel   | handshake          | beat
// ----------+--------------------+--------------------------------------------
// particle  | push / full        | particle_t: mass, position, velocity, last
// result    | pop / empty        | result_t: index, new state, event, last
// cfg       | cfg_valid/cfg_ready| cfg_index (0 width, 1 height), cfg_data
//
// Loading accepts one particle per cycle while full is low; full stays high from the last
// beat of a frame until every job of that frame is in the job queue. Per particle the front
// checks the walls, then, with no wall hit, scans partners (box test, then squared distance)
// to the first close one and pushes a job. The back passes other jobs on; a collision runs
// two axes of multiply, sum and restoring divide. Result stalls back up into the queue.
// Synchronous reset clears load count, queue and result valid; arena registers go to 500.
module particle_bounce_elastic_collide (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pbc_pkg::particle_t  particle,
  output logic                empty,
  input  logic                pop,
  output pbc_pkg::result_t    result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [14:0]         cfg_data
);
  import pbc_pkg::*;

  logic [14:0] arena_width;
  logic [14:0] arena_height;
  job_t        fr_job;
  job_t        bk_job;
  logic        fr_push;
  logic        q_full;
  logic        q_empty;
  logic        bk_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_width  <= ARENA_RESET;
      arena_height <= ARENA_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  arena_width  <= cfg_data;
        CFG_HEIGHT: arena_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pbc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .particle     (particle),
    .arena_width  (arena_width),
    .arena_height (arena_height),
    .job_push     (fr_push),
    .job_full     (q_full),
    .job          (fr_job)
  );

  pbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fr_push),
    .full    (q_full),
    .wr_data (fr_job),
    .pop     (bk_pop),
    .empty   (q_empty),
    .rd_data (bk_job)
  );

  pbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (bk_job),
    .job_empty (q_empty),
    .job_pop   (bk_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.event_kind <= EV_COLLIDE))
    else $error("event code out of range");

  a_left_clamp: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.event_kind == EV_LEFT) |-> (result.new_pos_x == 0))
    else $error("left wall result not clamped");

  a_top_clamp: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.event_kind == EV_TOP) |-> (result.new_pos_y == 0))
    else $error("top wall result not clamped");

endmodule
